### rtl/core/chebyshev_series_evaluator_macros.svh
// ----------------------------------------------------------------------------
// Chebyshev series evaluator - assertion macros
// Clocked assertion shorthands; the using module provides clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef CHEBYSHEV_SERIES_EVALUATOR_MACROS_SVH
`define CHEBYSHEV_SERIES_EVALUATOR_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define CSE_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent implies consequent, same edge; the consequent may hold a ## delay.
`define CSE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/cse_pkg.sv
// ----------------------------------------------------------------------------
// Chebyshev series evaluator package
// Payload types, command codes and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

  localparam int unsigned COEFF_IDX_W = 6;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ACC_W       = 48;

  localparam logic [CFG_W-1:0] NUM_COEFFS_RESET = 7'd64;

  // 1.0 in Q2.30
  localparam logic signed [DATA_W-1:0] ONE_Q30 = 32'sh4000_0000;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [COEFF_IDX_W-1:0]   coeff_index;
    logic signed [DATA_W-1:0] coeff_value;
    logic signed [DATA_W-1:0] point;
  } cse_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     out_of_range;
  } cse_out_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL_LO = 5'b00010,
    ST_MUL_HI = 5'b00100,
    ST_SUM    = 5'b01000,
    ST_ACC    = 5'b10000
  } state_e;

endpackage

`default_nettype wire

### rtl/core/chebyshev_series_evaluator.sv
// ----------------------------------------------------------------------------
// Chebyshev series evaluator
// Clenshaw evaluation of a stored Chebyshev series at the negated Q2.30 point.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A coefficient write
// (kind 0) leaves busy low, so writes can stream one per clock. An evaluate
// command (kind 1) holds busy high until it has walked the n coefficients, n
// being the effective coefficient count (num_coeffs, with 0 read as 1 and
// values above MAX_COEFFS read as MAX_COEFFS). Each coefficient passes through
// the recurrence step: low and high partial products of the 48 x 33 bit
// multiply, recombination, accumulate and saturate, fed by the single read
// port of the coefficient memory. The result appears for exactly one cycle
// with result_strobe_o high; the receiver cannot stall, so it must take the
// transfer in that cycle. Entries of the coefficient memory are undefined
// until written: evaluating over an unwritten entry gives an undefined value.
// num_coeffs is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chebyshev_series_evaluator_macros.svh"

module chebyshev_series_evaluator
  import cse_pkg::*;
#(
  parameter int unsigned MAX_COEFFS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  // command
  input  wire logic             start,
  output logic                  busy,
  input  wire cse_in_t          cmd_i,
  // result
  output logic                  result_strobe_o,
  output cse_out_t              result_o
);

  // Memory address width, index extension width, count width (holds MAX_COEFFS)
  localparam int unsigned AW = $clog2(MAX_COEFFS);
  localparam int unsigned IW = (AW > COEFF_IDX_W) ? AW : COEFF_IDX_W;
  localparam int unsigned CW = ((AW + 1) > CFG_W) ? (AW + 1) : CFG_W;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [CFG_W-1:0] num_coeffs_q;
  logic             result_strobe_q;

  logic             accept;
  logic             eval_go;
  logic             mem_we;

  // Datapath registers (no reset)
  logic [AW-1:0]             idx_q;    // index of coefficient being applied
  logic                      final_q;  // last phase: y*d - dd + c0/2
  logic signed [32:0]        y_q;      // -X, Q2.30 in 33 bits
  logic                      oor_q;
  logic signed [ACC_W-1:0]   d_q, dd_q;
  logic signed [49:0]        p_lo_q;   // d[15:0] * y
  logic signed [64:0]        p_hi_q;   // d[47:16] * y
  logic signed [48:0]        t_q;      // c - dd
  logic signed [50:0]        prod_q;   // floor(d*y / 2^29 or 2^30)
  cse_out_t                  result_q;

  // Coefficient memory
  logic signed [DATA_W-1:0]  coeff_mem_q [MAX_COEFFS];
  logic signed [DATA_W-1:0]  rd_q;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic [IW-1:0]             wr_idx_ext;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign eval_go = accept && (cmd_i.kind == KIND_EVAL);

  // Writes beyond the memory are dropped
  assign wr_idx_ext = IW'(cmd_i.coeff_index);
  assign wr_addr    = wr_idx_ext[AW-1:0];
  assign mem_we     = accept && (cmd_i.kind == KIND_WRITE) &&
                      (32'(cmd_i.coeff_index) < MAX_COEFFS);

  // Effective count: zero acts as one, clamp to memory depth
  logic [CW-1:0] n_raw, n_nz, n_eff;
  logic [AW-1:0] top_idx;

  always_comb begin
    n_raw   = CW'(num_coeffs_q);
    n_nz    = (n_raw == '0) ? CW'(1) : n_raw;
    n_eff   = (n_nz > CW'(MAX_COEFFS)) ? CW'(MAX_COEFFS) : n_nz;
    top_idx = AW'(n_eff - CW'(1));
  end

  // Read issued at the accept edge (top coefficient) and at every accumulate
  // edge (next one down); data lands in rd_q for the following MUL_LO cycle.
  // A write and a dependent read never share an edge: writes are only taken
  // while idle, and the first read of an evaluation follows them.
  always_comb begin
    if (state_q == ST_IDLE) begin
      rd_addr = top_idx;
    end else if (state_q == ST_ACC) begin
      rd_addr = idx_q - AW'(1);
    end else begin
      rd_addr = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      coeff_mem_q[wr_addr] <= cmd_i.coeff_value;
    end
    rd_q <= coeff_mem_q[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Arithmetic
  // --------------------------------------------------------------------------
  logic signed [32:0]      pt_ext;
  logic                    oor_d;
  logic signed [DATA_W-1:0] c_term;
  logic signed [80:0]      full_prod;
  logic signed [51:0]      acc_sum;
  logic signed [ACC_W-1:0] sat48;
  logic signed [DATA_W-1:0] sat32;

  always_comb begin
    pt_ext    = {cmd_i.point[DATA_W-1], cmd_i.point};
    oor_d     = (cmd_i.point > ONE_Q30) || (cmd_i.point < -ONE_Q30);
    // c0 is halved (floor) on the final phase
    c_term    = final_q ? (rd_q >>> 1) : rd_q;
    full_prod = $signed({p_hi_q, 16'h0000}) + 81'(p_lo_q);
    acc_sum   = 52'(prod_q) + 52'(t_q);
    // saturate on sign-bit disagreement above the target width
    if ((acc_sum[51:47] == 5'b00000) || (acc_sum[51:47] == 5'b11111)) begin
      sat48 = acc_sum[47:0];
    end else begin
      sat48 = acc_sum[51] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
    end
    if ((acc_sum[51:31] == '0) || (acc_sum[51:31] == '1)) begin
      sat32 = acc_sum[31:0];
    end else begin
      sat32 = acc_sum[51] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (eval_go) begin
          state_d = ST_MUL_LO;
        end
      end
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_SUM;
      ST_SUM:    state_d = ST_ACC;
      ST_ACC: begin
        state_d = final_q ? ST_IDLE : ST_MUL_LO;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      num_coeffs_q    <= NUM_COEFFS_RESET;
      result_strobe_q <= 1'b0;
    end else begin
      state_q         <= state_d;
      result_strobe_q <= (state_q == ST_ACC) && final_q;
      if (cfg_we_i) begin
        num_coeffs_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (eval_go) begin
          y_q     <= -pt_ext;
          oor_q   <= oor_d;
          d_q     <= '0;
          dd_q    <= '0;
          idx_q   <= top_idx;
          final_q <= (top_idx == '0);
        end
      end
      ST_MUL_LO: begin
        p_lo_q <= 50'($signed({1'b0, d_q[15:0]})) * 50'(y_q);
        t_q    <= 49'(c_term) - 49'(dd_q);
      end
      ST_MUL_HI: begin
        p_hi_q <= 65'($signed(d_q[47:16])) * 65'(y_q);
      end
      ST_SUM: begin
        // 2*y*d back to Q.30 on steps, y*d on the final phase
        prod_q <= final_q ? full_prod[80:30] : full_prod[79:29];
      end
      ST_ACC: begin
        if (final_q) begin
          result_q.value        <= sat32;
          result_q.out_of_range <= oor_q;
        end else begin
          dd_q    <= d_q;
          d_q     <= sat48;
          idx_q   <= idx_q - AW'(1);
          final_q <= (idx_q == AW'(1));
        end
      end
      default: ;
    endcase
  end

  assign result_strobe_o = result_strobe_q;
  assign result_o        = result_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CSE_ASSERT_IMPL(a_strobe_single, result_strobe_q, ##1 !result_strobe_q, "strobe too long")
  `CSE_ASSERT_IMPL(a_res_src, result_strobe_q, $past(state_q == ST_ACC && final_q), "stray result")
  `CSE_ASSERT_IMPL(a_busy_end, $fell(busy), result_strobe_q, "evaluation ended without result")
  `CSE_ASSERT_IMPL(a_idx_live, busy && !final_q, idx_q != '0, "index hit zero early")

endmodule

`default_nettype wire
